@@ src/mime_encoded_word_decoder_unit_macros.svh @@
// Assertion macros shared by the decoder RTL.
// Each macro takes a label, the clock, the active-low reset, a condition
// and a consequence.
`ifndef MIME_ENCODED_WORD_DECODER_UNIT_MACROS_SVH
`define MIME_ENCODED_WORD_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// The consequence must hold in the same cycle as the condition.
`define MEWD_ASSERT_NOW(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("decoder assertion failed");

// The consequence must hold in the cycle after the condition.
`define MEWD_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("decoder assertion failed");

`else

`define MEWD_ASSERT_NOW(label, clk, rst_n, cond, conseq)
`define MEWD_ASSERT_NEXT(label, clk, rst_n, cond, conseq)

`endif

`endif

@@ src/mewd_pkg.sv @@
`timescale 1ns / 1ps

package mewd_pkg;

    // Word modes.
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_Q     = 2'd1;
    localparam logic [1:0] MODE_B     = 2'd2;

    // Characters of interest.
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_UPPER_B = 8'h42;
    localparam logic [7:0] CH_UPPER_Q = 8'h51;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] BAD_DIGIT = 8'hFF;

    // Masks for reassembling base64 sextets.
    localparam logic [7:0] MASK_HI2  = 8'h30;
    localparam logic [7:0] MASK_LO4  = 8'h0F;
    localparam logic [7:0] MASK_MID4 = 8'h3C;
    localparam logic [7:0] MASK_LO2  = 8'h03;
    localparam logic [7:0] B64_PLUS  = 8'd62;
    localparam logic [7:0] B64_SLASH = 8'd63;

    // One item can give at most this many results.
    localparam int MAX_RESULTS = 4;
    localparam int SLOT_W      = $clog2(MAX_RESULTS);
    localparam int SCNT_W      = $clog2(MAX_RESULTS + 1);

    // One result beat.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       repl;
    } slot_t;

    // All results of one input item, queued between front and back.
    typedef struct packed {
        logic [SCNT_W-1:0]            count;
        slot_t [MAX_RESULTS-1:0]      slot;
    } bundle_t;

    // Decoder state carried from one input byte to the next.
    typedef struct packed {
        logic [1:0]       mode;
        logic             translated;
        logic [1:0]       opener_qcount;
        logic [2:0][7:0]  held;
        logic [1:0]       held_count;
        logic             pend_question;
        logic             pend_equals;
        logic             skip_space;
        logic             stopped;
    } dec_state_t;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic head_valid;
    } q_status_t;

    // Hex digit value, all ones when the character is not a digit.
    function automatic logic [7:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h61 + 8'd10;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h41 + 8'd10;
        end else begin
            v = BAD_DIGIT;
        end
        return v;
    endfunction

    // Base64 digit value, all ones when the character is not a digit.
    function automatic logic [7:0] b64_val(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = c - 8'h61 + 8'd26;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30 + 8'd52;
        end else if (c == CH_PLUS) begin
            v = B64_PLUS;
        end else if (c == CH_SLASH) begin
            v = B64_SLASH;
        end else begin
            v = BAD_DIGIT;
        end
        return v;
    endfunction

endpackage

@@ src/mewd_front.sv @@
`timescale 1ns / 1ps

module mewd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [7:0]           in_byte,
    input  logic                 end_of_line,
    input  mewd_pkg::q_status_t  q_status,
    output logic                 push,
    output mewd_pkg::bundle_t    push_data
);
    import mewd_pkg::*;

    typedef struct packed {
        dec_state_t st;
        bundle_t    bd;
    } work_t;

    dec_state_t state_reg;
    dec_state_t state_next;
    work_t      work;
    logic       accept;

    // Append one result to the bundle.
    function automatic work_t emit(input work_t w, input logic [7:0] b,
                                   input logic last, input logic repl);
        work_t r;
        r = w;
        if (r.bd.count < SCNT_W'(MAX_RESULTS)) begin
            r.bd.slot[r.bd.count[SLOT_W-1:0]] = '{data: b, last: last, repl: repl};
            r.bd.count = r.bd.count + SCNT_W'(1);
        end
        return r;
    endfunction

    // A byte at a character position, after any closing '?' has been handled.
    function automatic work_t char_body(input work_t w, input logic [7:0] b);
        work_t r;
        r = w;
        if (b == CH_LF) begin
            r = emit(r, 8'h00, 1'b1, 1'b1);
            r.st.stopped = 1'b1;
        end else if ((r.st.mode == MODE_Q || r.st.mode == MODE_B) && b == CH_UNDER) begin
            r = emit(r, CH_SPACE, 1'b0, 1'b0);
        end else if (r.st.mode == MODE_Q && b == CH_EQUALS) begin
            r.st.held_count = 2'd1;
        end else if (r.st.mode == MODE_B) begin
            r.st.held[0]    = b;
            r.st.held_count = 2'd1;
        end else if (b == CH_EQUALS && r.st.mode == MODE_PLAIN) begin
            r.st.pend_equals = 1'b1;
        end else begin
            r = emit(r, b, 1'b0, 1'b0);
        end
        return r;
    endfunction

    // A byte at a character position, where a '?' may open a close.
    function automatic work_t char_pos(input work_t w, input logic [7:0] b);
        work_t r;
        r = w;
        if (b == CH_QMARK) begin
            r.st.pend_question = 1'b1;
        end else begin
            r = char_body(r, b);
        end
        return r;
    endfunction

    // Second or later character of an escape or a base64 quad.
    function automatic work_t raw_digit(input work_t w, input logic [7:0] b);
        work_t      r;
        logic [7:0] v1;
        logic [7:0] v2;
        logic [7:0] v3;
        r  = w;
        v1 = b64_val(r.st.held[0]);
        v2 = b64_val(r.st.held[1]);
        v3 = b64_val(r.st.held[2]);
        if (r.st.mode == MODE_Q) begin
            if (r.st.held_count == 2'd1) begin
                r.st.held[1]    = b;
                r.st.held_count = 2'd2;
            end else begin
                r = emit(r, 8'(hex_val(r.st.held[1]) << 4) | hex_val(b), 1'b0, 1'b0);
                r.st.translated = 1'b1;
                r.st.held_count = 2'd0;
            end
        end else if (r.st.held_count == 2'd1) begin
            r.st.held[1] = b;
            if (r.st.held[0] == CH_EQUALS || b == CH_EQUALS) begin
                r.st.mode       = MODE_PLAIN;
                r.st.held_count = 2'd0;
            end else begin
                r.st.held_count = 2'd2;
            end
        end else if (r.st.held_count == 2'd2) begin
            r.st.held[2]    = b;
            r.st.held_count = 2'd3;
        end else begin
            r = emit(r, 8'(v1 << 2) | 8'((v2 & MASK_HI2) >> 4), 1'b0, 1'b0);
            if (r.st.held[2] == CH_EQUALS) begin
                r.st.mode = MODE_PLAIN;
            end else begin
                r = emit(r, 8'((v2 & MASK_LO4) << 4) | 8'((v3 & MASK_MID4) >> 2),
                         1'b0, 1'b0);
                if (b == CH_EQUALS) begin
                    r.st.mode = MODE_PLAIN;
                end else begin
                    r = emit(r, 8'((v3 & MASK_LO2) << 6) | b64_val(b), 1'b0, 1'b0);
                end
            end
            r.st.translated = 1'b1;
            r.st.held_count = 2'd0;
        end
        return r;
    endfunction

    // One character byte of the line.
    function automatic work_t feed(input work_t w, input logic [7:0] b);
        work_t r;
        r = w;
        if (r.st.stopped) begin
            r = w;
        end else if (r.st.opener_qcount != 2'd0) begin
            if (b == CH_QMARK) begin
                r.st.opener_qcount = (r.st.opener_qcount >= 2'd2) ? 2'd0
                                                                  : r.st.opener_qcount + 2'd1;
            end else if (r.st.opener_qcount == 2'd2) begin
                if (b == CH_UPPER_Q) begin
                    r.st.mode       = MODE_Q;
                    r.st.translated = 1'b0;
                end else if (b == CH_UPPER_B) begin
                    r.st.mode       = MODE_B;
                    r.st.translated = 1'b0;
                end
            end
        end else if (r.st.held_count != 2'd0) begin
            r = raw_digit(r, b);
        end else if (r.st.pend_question) begin
            r.st.pend_question = 1'b0;
            if (b == CH_EQUALS) begin
                if (r.st.mode != MODE_PLAIN || r.st.translated) begin
                    r.st.mode       = MODE_PLAIN;
                    r.st.skip_space = 1'b1;
                end else begin
                    r = char_body(r, CH_EQUALS);
                end
            end else begin
                // The held '?' was ordinary; in base64 mode it opens a quad.
                r = char_body(r, CH_QMARK);
                if (r.st.held_count != 2'd0) begin
                    r = raw_digit(r, b);
                end else begin
                    r = char_pos(r, b);
                end
            end
        end else if (r.st.pend_equals) begin
            r.st.pend_equals = 1'b0;
            if (b == CH_QMARK) begin
                r.st.opener_qcount = 2'd1;
            end else begin
                r = emit(r, CH_EQUALS, 1'b0, 1'b0);
                r = char_pos(r, b);
            end
        end else if (r.st.skip_space && b == CH_SPACE) begin
            r.st.skip_space = 1'b0;
        end else begin
            r.st.skip_space = 1'b0;
            r = char_pos(r, b);
        end
        return r;
    endfunction

    // Classify the offered beat and work out its results and next state.
    always_comb
    begin
        work.st = state_reg;
        work.bd = '0;
        if (end_of_line) begin
            if (!state_reg.stopped) begin
                if (state_reg.pend_question && state_reg.held_count == 2'd0 &&
                    state_reg.mode != MODE_B) begin
                    work = emit(work, CH_QMARK, 1'b0, 1'b0);
                end
                if (state_reg.pend_equals) begin
                    work = emit(work, CH_EQUALS, 1'b0, 1'b0);
                end
                work = emit(work, 8'h00, 1'b1, state_reg.translated);
            end
            work.st = '0;
        end else begin
            work = feed(work, in_byte);
        end
    end

    assign item_stall = q_status.full;
    assign accept     = item_valid && !q_status.full;
    assign push       = accept && (work.bd.count != '0);
    assign push_data  = work.bd;
    assign state_next = accept ? work.st : state_reg;

    // Decoder state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/mewd_queue.sv @@
`timescale 1ns / 1ps

module mewd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mewd_pkg::bundle_t    push_data,
    input  logic                 pop,
    output mewd_pkg::q_status_t  q_status,
    output mewd_pkg::bundle_t    head_data
);
    import mewd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bundle_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;

    assign q_status.full       = (fill_reg == CNT_W'(DEPTH));
    assign q_status.head_valid = (fill_reg != '0);
    assign head_data           = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Bundle storage.
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/mewd_back.sv @@
`timescale 1ns / 1ps

module mewd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mewd_pkg::q_status_t  q_status,
    input  mewd_pkg::bundle_t    head_data,
    output logic                 pop,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [7:0]           out_byte,
    output logic                 is_last,
    output logic                 replace_original
);
    import mewd_pkg::*;

    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] idx_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    slot_t             out_reg;
    slot_t             cur_slot;
    logic              load;
    logic              last_slot;

    // The output register loads when empty or when its beat is taken.
    assign load      = !out_valid_reg || !result_stall;
    assign cur_slot  = head_data.slot[idx_reg];
    assign last_slot = (SCNT_W'(idx_reg) + SCNT_W'(1)) == head_data.count;
    assign pop       = load && q_status.head_valid && last_slot;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = q_status.head_valid;
            if (q_status.head_valid) begin
                idx_next = last_slot ? '0 : idx_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (load && q_status.head_valid) begin
            out_reg <= cur_slot;
        end
    end

    assign result_valid     = out_valid_reg;
    assign out_byte         = out_reg.data;
    assign is_last          = out_reg.last;
    assign replace_original = out_reg.repl;

endmodule

@@ src/mime_encoded_word_decoder_unit.sv @@
`timescale 1ns / 1ps

// Decodes MIME encoded words in a header line, one byte beat in and one
// result beat out per cycle while neither side is stalled. The front part
// takes a byte in every cycle in which the bundle queue (QUEUE_DEPTH
// entries) has room, works out all of that byte's results in the same
// cycle and queues them as one bundle; a byte with no results leaves
// nothing in the queue. The back part sends one result per cycle, while
// result_stall is low, from the queue head through a registered output. A
// closing base64 digit can give three results, and a terminator or a byte
// that releases a held character can give two, so a run of such items is
// paced by the single result port: the input stalls once the queue fills.
module mime_encoded_word_decoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_line,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_byte,
    output logic       is_last,
    output logic       replace_original
);
    import mewd_pkg::*;

`include "mime_encoded_word_decoder_unit_macros.svh"

    q_status_t q_status;
    bundle_t   push_data;
    bundle_t   head_data;
    logic      push;
    logic      pop;

    // Front part: accepts and decodes bytes.
    mewd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .in_byte    (in_byte),
        .end_of_line(end_of_line),
        .q_status   (q_status),
        .push       (push),
        .push_data  (push_data)
    );

    // Bundle queue between the two parts.
    mewd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .q_status (q_status),
        .head_data(head_data)
    );

    // Back part: sends the queued results one beat at a time.
    mewd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_status        (q_status),
        .head_data       (head_data),
        .pop             (pop),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .out_byte        (out_byte),
        .is_last         (is_last),
        .replace_original(replace_original)
    );

    // A bundle is never written into a full queue.
    `MEWD_ASSERT_NOW(a_no_push_when_full, clk, rst_n, push, !q_status.full)
    // The back part only retires a bundle that is present.
    `MEWD_ASSERT_NOW(a_pop_needs_head, clk, rst_n, pop, q_status.head_valid)
    // The closing beat of a line carries no character.
    `MEWD_ASSERT_NOW(a_last_is_zero, clk, rst_n, result_valid && is_last, out_byte == 8'h00)
    // The replace flag is only raised on the closing beat.
    `MEWD_ASSERT_NOW(a_repl_on_last, clk, rst_n, result_valid && replace_original, is_last)

endmodule
